// File: rtl/core/lpsc_pkg.sv
package lpsc_pkg;

    localparam int unsigned LEN_SIZE_MAX = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH_SIZE  = 2'd0,
        CFG_PASS_THROUGH = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       unit_end;
        logic       failed;
    } out_t;

    // one queue entry: a single result or a whole start code
    typedef struct packed {
        logic       start;
        logic       long_code;
        logic [7:0] data;
        logic       unit_end;
        logic       failed;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_PAY  = 3'b010,
        PH_DISC = 3'b100
    } phase_t;

endpackage

// File: rtl/core/lpsc_front.sv
module lpsc_front
    import lpsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_fire,
    input  in_t                   in_item,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [2:0]  length_size_reg;
    logic        pass_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  seen_reg, seen_next;
    logic [31:0] acc_reg, acc_next;
    logic [30:0] left_reg, left_next;
    logic        first_reg, first_next;

    logic [2:0]  size_eff;
    logic [31:0] acc_new;
    logic [2:0]  seen_new;
    logic [31:0] nal;
    logic [30:0] left_dec;
    logic        conv_clr;
    logic        last;
    logic [7:0]  b;

    assign last = in_item.buffer_last;
    assign b    = in_item.data_byte;

    always_comb begin
        if (length_size_reg == 3'd0) begin
            size_eff = 3'd1;
        end else if (length_size_reg > 3'(LEN_SIZE_MAX)) begin
            size_eff = 3'(LEN_SIZE_MAX);
        end else begin
            size_eff = length_size_reg;
        end
    end

    assign acc_new  = {acc_reg[23:0], b};
    assign seen_new = (seen_reg == 3'd7) ? seen_reg : seen_reg + 3'd1;
    assign left_dec = left_reg - 31'd1;

    always_comb begin
        unique case (size_eff)
            3'd1:    nal = {24'd0, acc_new[7:0]};
            3'd2:    nal = {16'd0, acc_new[15:0]};
            3'd3:    nal = {8'd0, acc_new[23:0]};
            default: nal = acc_new;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        first_next = first_reg;
        conv_clr   = 1'b0;
        push       = 1'b0;
        push_cmd   = '0;
        if (in_fire) begin
            if (pass_reg) begin
                push              = 1'b1;
                push_cmd.data     = b;
                push_cmd.unit_end = last;
                conv_clr          = last;
            end else begin
                unique case (phase_reg)
                    PH_DISC: begin
                        conv_clr = last;
                    end
                    PH_PAY: begin
                        push = 1'b1;
                        if (last && left_reg != 31'd1) begin
                            push_cmd.unit_end = 1'b1;
                            push_cmd.failed   = 1'b1;
                        end else begin
                            push_cmd.data     = b;
                            push_cmd.unit_end = last;
                            left_next         = left_dec;
                            if (left_dec == 31'd0) begin
                                phase_next = PH_LEN;
                            end
                        end
                        conv_clr = last;
                    end
                    PH_LEN: begin
                        acc_next  = acc_new;
                        seen_next = seen_new;
                        if (seen_new < size_eff) begin
                            if (last) begin
                                push              = 1'b1;
                                push_cmd.unit_end = 1'b1;
                                push_cmd.failed   = 1'b1;
                                conv_clr          = 1'b1;
                            end
                        end else begin
                            seen_next = '0;
                            acc_next  = '0;
                            push      = 1'b1;
                            conv_clr  = last;
                            // negative 4-byte length, or buffer ends before payload
                            if ((size_eff == 3'(LEN_SIZE_MAX) && nal[31]) ||
                                (last && nal != 32'd0)) begin
                                push_cmd.unit_end = 1'b1;
                                push_cmd.failed   = 1'b1;
                                if (!last) begin
                                    phase_next = PH_DISC;
                                end
                            end else begin
                                push_cmd.start     = 1'b1;
                                push_cmd.long_code = first_reg;
                                push_cmd.unit_end  = last;
                                first_next         = 1'b0;
                                if (nal != 32'd0) begin
                                    phase_next = PH_PAY;
                                    left_next  = nal[30:0];
                                end
                            end
                        end
                    end
                    default: begin
                        conv_clr = 1'b1;
                    end
                endcase
            end
        end
        if (conv_clr) begin
            phase_next = PH_LEN;
            seen_next  = '0;
            acc_next   = '0;
            left_next  = '0;
            first_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_size_reg <= 3'(LEN_SIZE_MAX);
            pass_reg        <= 1'b1;
            phase_reg       <= PH_LEN;
            seen_reg        <= '0;
            acc_reg         <= '0;
            left_reg        <= '0;
            first_reg       <= 1'b1;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_LENGTH_SIZE) begin
                    length_size_reg <= cfg_data;
                end else if (cfg_index == CFG_PASS_THROUGH) begin
                    pass_reg <= cfg_data[0];
                end
            end
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: rtl/core/lpsc_queue.sv
module lpsc_queue
    import lpsc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: rtl/core/lpsc_back.sv
module lpsc_back
    import lpsc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;
    logic [1:0] rem_reg, rem_next;
    logic       ue_reg, ue_next;
    logic       load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rem_next     = rem_reg;
        ue_next      = ue_reg;
        pop          = 1'b0;
        if (load) begin
            if (rem_reg != 2'd0) begin
                // rest of a start code, ending in the 01 byte
                m_valid_next         = 1'b1;
                m_data_next.out_byte = (rem_reg == 2'd1) ? 8'h01 : 8'h00;
                m_data_next.run_last = (rem_reg == 2'd1);
                m_data_next.unit_end = (rem_reg == 2'd1) && ue_reg;
                m_data_next.failed   = 1'b0;
                rem_next             = rem_reg - 2'd1;
            end else if (!q_empty) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                if (q_head.start) begin
                    m_data_next = '0;
                    rem_next    = q_head.long_code ? 2'd3 : 2'd2;
                    ue_next     = q_head.unit_end;
                end else begin
                    m_data_next.out_byte = q_head.data;
                    m_data_next.run_last = 1'b1;
                    m_data_next.unit_end = q_head.unit_end;
                    m_data_next.failed   = q_head.failed;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        ue_reg     <= ue_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rem_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

// File: rtl/core/length_prefix_to_start_code_unit.sv
// Rewrites length-prefixed access units into start-code form, one byte per item.
// Input channel s_valid/s_ready/s_data carries a byte and a buffer-last flag;
// result channel m_valid/m_ready/m_data carries one output byte with its flags.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes length_size (0)
// and pass_through (1); cfg_ready is always high, write only while idle.
// Results are registered in the command queue, then in the output register.
// Throughput: one input item per cycle while the queue has room and each item
// gives at most one result; a completed length expands to a 3 or 4 byte start
// code; while m_ready is high, the output register gives one result per cycle.
// The front classifies items into a QUEUE_DEPTH entry command queue; s_ready
// drops only when that queue is full, so a stalled receiver backs up through
// the output register and the queue before input is held off.
// Reset puts length_size at 4, pass_through at 1, empties the queue and the
// output register, and returns the conversion to the start of a buffer.
module length_prefix_to_start_code_unit
    import lpsc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_head;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;

    lpsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (s_valid && s_ready),
        .in_item   (s_data),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    lpsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: bench/tb_top.sv
module tb_top;
    import lpsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies as last written
    logic [2:0]  len_size_reg = 3'd4;
    logic        pass_reg     = 1'b1;

    // conversion state of the prediction
    phase_t      conv_phase = PH_LEN;
    logic [2:0]  len_seen   = '0;
    logic [31:0] len_acc    = '0;
    logic [30:0] pay_left   = '0;
    logic        first_nal  = 1'b1;

    in_t  bytes_to_send[$];
    out_t out_bytes_due[$];
    int   bytes_queued   = 0;
    int   bytes_sent     = 0;
    int   bad_results    = 0;
    int   burst_left     = 0;
    int   gap_left       = 0;
    int   quiet_cycles   = 0;
    bit [15:0] rx_cycle  = '0;

    length_prefix_to_start_code_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void owe_result(logic [7:0] b, logic rl, logic ue, logic f);
        out_bytes_due.push_back('{out_byte: b, run_last: rl, unit_end: ue, failed: f});
    endfunction

    function automatic void restart_buffer();
        conv_phase = PH_LEN;
        len_seen   = '0;
        len_acc    = '0;
        pay_left   = '0;
        first_nal  = 1'b1;
    endfunction

    function automatic void malformed(logic at_end);
        owe_result(8'h00, 1'b1, 1'b1, 1'b1);
        if (at_end) begin
            restart_buffer();
        end else begin
            conv_phase = PH_DISC;
        end
    endfunction

    function automatic int eff_len_size();
        if (len_size_reg == 3'd0) begin
            return 1;
        end
        return (len_size_reg > 3'd4) ? 4 : int'(len_size_reg);
    endfunction

    // expected results of one accepted item
    function automatic void rewrite_byte(in_t it);
        logic [2:0]  sz;
        logic [31:0] nal;
        logic        lst;
        int          n;
        int          i;
        lst = it.buffer_last;
        if (pass_reg) begin
            owe_result(it.data_byte, 1'b1, lst, 1'b0);
            if (lst) begin
                restart_buffer();
            end
        end else begin
            sz = 3'(eff_len_size());
            case (conv_phase)
                PH_DISC: begin
                    if (lst) begin
                        restart_buffer();
                    end
                end
                PH_PAY: begin
                    if (lst && pay_left != 31'd1) begin
                        malformed(1'b1);
                    end else begin
                        owe_result(it.data_byte, 1'b1, lst, 1'b0);
                        pay_left = pay_left - 31'd1;
                        if (lst) begin
                            restart_buffer();
                        end else if (pay_left == 31'd0) begin
                            conv_phase = PH_LEN;
                        end
                    end
                end
                default: begin
                    len_acc = {len_acc[23:0], it.data_byte};
                    if (len_seen < 3'd7) begin
                        len_seen = len_seen + 3'd1;
                    end
                    if (len_seen < sz) begin
                        if (lst) begin
                            malformed(1'b1);
                        end
                    end else begin
                        // a size shrunk mid-length keeps only its low bytes
                        nal = (sz == 3'd4) ? len_acc : len_acc & ((32'd1 << (8 * sz)) - 32'd1);
                        len_seen = '0;
                        len_acc  = '0;
                        if (sz == 3'd4 && nal[31]) begin
                            malformed(lst);
                        end else if (lst && nal != 32'd0) begin
                            malformed(1'b1);
                        end else begin
                            n = first_nal ? 4 : 3;
                            for (i = 0; i < n; i++) begin
                                owe_result((i == n - 1) ? 8'h01 : 8'h00, i == n - 1,
                                           (i == n - 1) && lst, 1'b0);
                            end
                            first_nal = 1'b0;
                            if (lst) begin
                                restart_buffer();
                            end else if (nal != 32'd0) begin
                                conv_phase = PH_PAY;
                                pay_left   = nal[30:0];
                            end
                        end
                    end
                end
            endcase
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic last);
        bytes_to_send.push_back('{data_byte: b, buffer_last: last});
        bytes_queued++;
    endfunction

    // one buffer: mostly well formed, some cut short, oversized or pure noise
    task automatic queue_buffer();
        logic [7:0]  bq[$];
        logic [31:0] lenv;
        int kind, units, plen, eff, cut, u, k;
        eff  = eff_len_size();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 12)) bq.push_back(8'($urandom));
        end else begin
            units = $urandom_range(1, 3);
            for (u = 0; u < units; u++) begin
                plen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                lenv = plen;
                if (kind == 8 && u == units - 1) begin
                    // length far beyond the buffer, negative half the time at four bytes
                    lenv = $urandom;
                    if (eff < 4) begin
                        lenv = lenv & ((32'd1 << (8 * eff)) - 32'd1);
                        lenv[8 * eff - 1] = 1'b1;
                    end
                    plen = $urandom_range(0, 5);
                end
                for (k = eff - 1; k >= 0; k--) begin
                    bq.push_back(lenv[8 * k +: 8]);
                end
                repeat (plen) bq.push_back(8'($urandom));
            end
            if (kind == 7) begin
                cut = $urandom_range(1, bq.size());
                bq  = bq[0:cut - 1];
            end
        end
        foreach (bq[j]) begin
            queue_byte(bq[j], j == bq.size() - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LENGTH_SIZE:  len_size_reg = val;
            CFG_PASS_THROUGH: pass_reg     = val[0];
            default: ;
        endcase
    endtask

    // all items in, all results out, then a wait for items that owe nothing
    task automatic settle();
        while (bytes_sent != bytes_queued || out_bytes_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rewrite_byte(s_data);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= bytes_to_send.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each item; the stall style changes with bits 8:7 of rx_cycle
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (out_bytes_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("unexpected result: byte %h run_last %b unit_end %b failed %b",
                                 m_data.out_byte, m_data.run_last, m_data.unit_end, m_data.failed);
                    end
                end else begin
                    want = out_bytes_due.pop_front();
                    if (m_data.out_byte !== want.out_byte || m_data.run_last !== want.run_last ||
                        m_data.unit_end !== want.unit_end || m_data.failed !== want.failed) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                     want.out_byte, want.run_last, want.unit_end, want.failed,
                                     m_data.out_byte, m_data.run_last, m_data.unit_end,
                                     m_data.failed);
                        end
                    end
                end
            end
            rx_cycle = rx_cycle + 16'd1;
            case (rx_cycle[8:7])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= rx_cycle[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int p;
        int phase_start;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings copy bytes straight through
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        settle();

        write_reg(CFG_LENGTH_SIZE, 3'd4);
        write_reg(CFG_PASS_THROUGH, 3'd0);
        // first and later start codes, empty final unit
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b1);
        // negative length, then dropped bytes up to the end
        queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h5A, 1'b1);
        // stop partway into a length and shrink the size under it
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        settle();
        write_reg(CFG_LENGTH_SIZE, 3'd1);
        queue_byte(8'h02, 1'b0); queue_byte(8'h11, 1'b0); queue_byte(8'h22, 1'b1);
        // buffer ends on a complete nonzero length
        queue_byte(8'h05, 1'b1);
        // buffer ends inside a payload
        queue_byte(8'h03, 1'b0); queue_byte(8'h7F, 1'b1);
        settle();

        for (p = 0; p < 8; p++) begin
            write_reg(CFG_LENGTH_SIZE, 3'(p));
            write_reg(CFG_PASS_THROUGH,
                      {2'($urandom), (p == 5) || ($urandom_range(0, 5) == 0)});
            if (p == 3) begin
                write_reg(CFG_UNUSED_LO, 3'($urandom));
                write_reg(CFG_UNUSED_HI, 3'($urandom));
            end
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_ITEMS) queue_buffer();
            // sometimes add one to three zero bytes, which can leave a partial length for the next setting to finish
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) queue_byte(8'h00, 1'b0);
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        if (bad_results == 0 && out_bytes_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: length_prefix_to_start_code_unit.f
rtl/core/lpsc_pkg.sv
rtl/core/lpsc_front.sv
rtl/core/lpsc_queue.sv
rtl/core/lpsc_back.sv
rtl/core/length_prefix_to_start_code_unit.sv
bench/tb_top.sv
